[sv/ssno_pkg.sv]
package ssno_pkg;

	// Default number of decimal digits kept from a value
	localparam int MAX_DIGITS = 5;

	// Field widths
	localparam int VALUE_W  = 17;
	localparam int JUST_W   = 2;
	localparam int OFFS_W   = 10;
	localparam int COLOR_W  = 32;
	localparam int COORD_W  = 17;
	localparam int SIZE_W   = 7;
	localparam int SCREEN_W = 12;
	localparam int ZOOM_W   = 6;
	localparam int DIGIT_W  = 4;
	localparam int SEG_N    = 7;

	// Stream word widths
	localparam int S_DATA_W = 72;
	localparam int M_DATA_W = 80;

	// Configuration port
	localparam int CFG_IDX_W = 2;
	localparam logic [CFG_IDX_W-1:0] REG_SCREEN_WIDTH  = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_SCREEN_HEIGHT = 2'd1;
	localparam logic [SCREEN_W-1:0] SCREEN_WIDTH_RST  = 12'd640;
	localparam logic [SCREEN_W-1:0] SCREEN_HEIGHT_RST = 12'd480;

	// Controller states
	typedef enum logic [2:0] {
		ST_IDLE,
		ST_SPLIT,
		ST_ORIGIN,
		ST_PLACE,
		ST_EMIT
	} state_t;

	// Controller to datapath
	typedef struct packed {
		logic load;
		logic split;
		logic mul;
		logic place;
		logic emit;
	} cmd_t;

	// Datapath to controller
	typedef struct packed {
		logic split_done;
		logic out_free;
		logic final_rect;
	} sts_t;

	// Segment placement in units of zoom
	typedef struct packed {
		logic [2:0] gx;
		logic [3:0] gy;
		logic       horiz;
	} seg_geom_t;

	// Lit segments of a decimal digit, bit i is segment i
	function automatic logic [SEG_N-1:0] seg_bits(input logic [DIGIT_W-1:0] digit);
		logic [SEG_N-1:0] bits;
		case (digit)
			4'd0: bits = 7'h77;
			4'd1: bits = 7'h24;
			4'd2: bits = 7'h5D;
			4'd3: bits = 7'h6D;
			4'd4: bits = 7'h2E;
			4'd5: bits = 7'h6B;
			4'd6: bits = 7'h7B;
			4'd7: bits = 7'h25;
			4'd8: bits = 7'h7F;
			4'd9: bits = 7'h6F;
			4'd10: bits = 7'h77;
			4'd11: bits = 7'h24;
			4'd12: bits = 7'h5D;
			4'd13: bits = 7'h6D;
			4'd14: bits = 7'h2E;
			default: bits = 7'h6B;
		endcase
		return bits;
	endfunction

	// Segment origin and orientation
	function automatic seg_geom_t seg_geom(input logic [2:0] seg);
		seg_geom_t g;
		case (seg)
			3'd0: g = '{gx: 3'd1, gy: 4'd0, horiz: 1'b1};
			3'd1: g = '{gx: 3'd0, gy: 4'd1, horiz: 1'b0};
			3'd2: g = '{gx: 3'd4, gy: 4'd1, horiz: 1'b0};
			3'd3: g = '{gx: 3'd1, gy: 4'd4, horiz: 1'b1};
			3'd4: g = '{gx: 3'd0, gy: 4'd5, horiz: 1'b0};
			3'd5: g = '{gx: 3'd4, gy: 4'd5, horiz: 1'b0};
			3'd6: g = '{gx: 3'd1, gy: 4'd8, horiz: 1'b1};
			default: g = '{gx: 3'd0, gy: 4'd0, horiz: 1'b0};
		endcase
		return g;
	endfunction

endpackage

[sv/ssno_ctrl.sv]
module ssno_ctrl (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              start,
	output logic              ready,
	input  ssno_pkg::sts_t    sts,
	output ssno_pkg::cmd_t    cmd
);

	ssno_pkg::state_t state_q;
	ssno_pkg::state_t state_d;

	// State register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ssno_pkg::ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// Next state and commands
	always_comb begin
		state_d = state_q;
		cmd     = '0;
		ready   = 1'b0;
		case (state_q)
			ssno_pkg::ST_IDLE: begin
				ready = 1'b1;
				if (start) begin
					cmd.load = 1'b1;
					state_d  = ssno_pkg::ST_SPLIT;
				end
			end
			ssno_pkg::ST_SPLIT: begin
				cmd.split = 1'b1;
				if (sts.split_done) begin
					state_d = ssno_pkg::ST_ORIGIN;
				end
			end
			ssno_pkg::ST_ORIGIN: begin
				cmd.mul = 1'b1;
				state_d = ssno_pkg::ST_PLACE;
			end
			ssno_pkg::ST_PLACE: begin
				cmd.place = 1'b1;
				state_d   = ssno_pkg::ST_EMIT;
			end
			ssno_pkg::ST_EMIT: begin
				if (sts.out_free) begin
					cmd.emit = 1'b1;
					if (sts.final_rect) begin
						state_d = ssno_pkg::ST_IDLE;
					end
				end
			end
			default: begin
				state_d = ssno_pkg::ST_IDLE;
			end
		endcase
	end

endmodule

[sv/ssno_dpath.sv]
module ssno_dpath #(
	parameter int MAX_DIGITS = ssno_pkg::MAX_DIGITS
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  ssno_pkg::cmd_t                    cmd,
	output ssno_pkg::sts_t                    sts,
	input  logic [ssno_pkg::S_DATA_W-1:0]     in_word,
	input  logic [ssno_pkg::SCREEN_W-1:0]     screen_width,
	input  logic [ssno_pkg::SCREEN_W-1:0]     screen_height,
	output logic                              out_valid,
	input  logic                              out_ready,
	output logic [ssno_pkg::M_DATA_W-1:0]     out_word,
	output logic                              out_last
);

	localparam int IDX_W = (MAX_DIGITS > 1) ? $clog2(MAX_DIGITS) : 1;
	localparam int CNT_W = $clog2(MAX_DIGITS + 1);
	localparam int VW    = ssno_pkg::VALUE_W;
	localparam int CW    = ssno_pkg::COORD_W;
	localparam int ZW    = ssno_pkg::ZOOM_W;
	localparam int SW    = ssno_pkg::SIZE_W;

	// Item registers
	logic [VW-1:0]                   val_q;
	logic [ssno_pkg::JUST_W-1:0]     just_q;
	logic [ssno_pkg::OFFS_W-1:0]     offh_q;
	logic [ssno_pkg::OFFS_W-1:0]     offv_q;
	logic [ssno_pkg::COLOR_W-1:0]    color_q;
	logic [ZW-1:0]                   zoom_q;
	logic [SW-1:0]                   zoom3_q;
	logic [CW-1:0]                   zoom7_q;
	logic [CNT_W-1:0]                cnt_q;
	logic [ssno_pkg::DIGIT_W-1:0]    digit_q [MAX_DIGITS];
	logic [CW-1:0]                   xm_q;
	logic [CW-1:0]                   ym_q;
	logic [CW-1:0]                   x_q;
	logic [CW-1:0]                   y_q;
	logic [IDX_W-1:0]                dig_idx_q;
	logic [ssno_pkg::SEG_N-1:0]      mask_q;

	// Output register
	logic                            out_valid_q;
	logic [CW-1:0]                   rx_q;
	logic [CW-1:0]                   ry_q;
	logic [SW-1:0]                   rw_q;
	logic [SW-1:0]                   rh_q;
	logic [ssno_pkg::COLOR_W-1:0]    col_q;
	logic                            last_q;

	// Zoom from the screen size: w/120 = (w>>3)/15, h/80 = (h>>4)/5
	logic [21:0]   zw_prod;
	logic [21:0]   zh_prod;
	logic [ZW-1:0] zw;
	logic [ZW-1:0] zh;
	logic [ZW-1:0] zoom;

	assign zw_prod = 22'(screen_width[11:3]) * 22'd4370;
	assign zh_prod = 22'(screen_height[11:4]) * 22'd13108;
	assign zw      = ZW'(zw_prod[21:16]) + ZW'(1);
	assign zh      = ZW'(zh_prod[21:16]) + ZW'(1);
	assign zoom    = (zh < zw) ? zh : zw;

	// One decimal digit per cycle: reciprocal estimate, one correction
	logic [30:0]   q_prod;
	logic [VW-1:0] q_est;
	logic [VW-1:0] r_est;
	logic [VW-1:0] q_fix;
	logic [ssno_pkg::DIGIT_W-1:0] r_fix;

	assign q_prod = 31'(val_q) * 31'd13107;
	assign q_est  = VW'(q_prod[30:17]);
	assign r_est  = val_q - VW'(q_est * VW'(10));
	always_comb begin
		if (r_est >= VW'(10)) begin
			q_fix = q_est + VW'(1);
			r_fix = ssno_pkg::DIGIT_W'(r_est - VW'(10));
		end else begin
			q_fix = q_est;
			r_fix = ssno_pkg::DIGIT_W'(r_est);
		end
	end

	assign sts.split_done = (q_fix == '0) || (cnt_q == CNT_W'(MAX_DIGITS - 1));

	// Origin multiplicands
	logic [10:0] xk;
	logic [10:0] yk;

	assign xk = just_q[0] ? (11'(offh_q) + 11'(cnt_q) * 11'd7 - 11'd2) : 11'(offh_q);
	assign yk = just_q[1] ? (11'(offv_q) + 11'd9) : 11'(offv_q);

	// Next segment of the current digit, lowest bit first
	logic [2:0]                 seg_sel;
	logic [ssno_pkg::SEG_N-1:0] mask_next;
	ssno_pkg::seg_geom_t        geom;
	logic                       digit_done;

	always_comb begin
		seg_sel = 3'd0;
		for (int i = ssno_pkg::SEG_N - 1; i >= 0; i--) begin
			if (mask_q[i]) begin
				seg_sel = 3'(i);
			end
		end
	end

	assign geom       = ssno_pkg::seg_geom(seg_sel);
	assign mask_next  = mask_q & ~(ssno_pkg::SEG_N'(1) << seg_sel);
	assign digit_done = (mask_next == '0);

	assign sts.final_rect = digit_done && (dig_idx_q == '0);
	assign sts.out_free   = !out_valid_q || out_ready;

	// Digit read port, shared by first load and digit advance
	logic [IDX_W-1:0]           rd_idx;
	logic [ssno_pkg::SEG_N-1:0] rd_bits;

	assign rd_idx  = cmd.place ? IDX_W'(cnt_q - CNT_W'(1)) : (dig_idx_q - IDX_W'(1));
	assign rd_bits = ssno_pkg::seg_bits(digit_q[rd_idx]);

	// Rectangle geometry
	logic [CW-1:0] rx;
	logic [CW-1:0] ry;

	assign rx = x_q + CW'(9'(geom.gx) * 9'(zoom_q));
	assign ry = y_q + CW'(10'(geom.gy) * 10'(zoom_q));

	// Item, digit and placement registers
	always_ff @(posedge clk) begin
		if (cmd.load) begin
			val_q   <= in_word[16:0];
			just_q  <= in_word[18:17];
			offh_q  <= in_word[28:19];
			offv_q  <= in_word[38:29];
			color_q <= in_word[70:39];
			zoom_q  <= zoom;
			cnt_q   <= '0;
		end
		if (cmd.split) begin
			digit_q[cnt_q[IDX_W-1:0]] <= r_fix;
			val_q                     <= q_fix;
			cnt_q                     <= cnt_q + CNT_W'(1);
		end
		if (cmd.mul) begin
			xm_q    <= CW'(xk) * CW'(zoom_q);
			ym_q    <= CW'(yk) * CW'(zoom_q);
			zoom3_q <= SW'(zoom_q) * SW'(3);
			zoom7_q <= CW'(zoom_q) * CW'(7);
		end
		if (cmd.place) begin
			x_q       <= just_q[0] ? (CW'(screen_width) - xm_q) : xm_q;
			y_q       <= just_q[1] ? (CW'(screen_height) - ym_q) : ym_q;
			dig_idx_q <= IDX_W'(cnt_q - CNT_W'(1));
			mask_q    <= rd_bits;
		end
		if (cmd.emit) begin
			if (digit_done) begin
				if (dig_idx_q != '0) begin
					dig_idx_q <= dig_idx_q - IDX_W'(1);
					mask_q    <= rd_bits;
				end
				x_q <= x_q + zoom7_q;
			end else begin
				mask_q <= mask_next;
			end
		end
	end

	// Output payload
	always_ff @(posedge clk) begin
		if (cmd.emit) begin
			rx_q   <= rx;
			ry_q   <= ry;
			rw_q   <= geom.horiz ? zoom3_q : SW'(zoom_q);
			rh_q   <= geom.horiz ? SW'(zoom_q) : zoom3_q;
			col_q  <= color_q;
			last_q <= sts.final_rect;
		end
	end

	// Output valid flag
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.emit) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	assign out_valid = out_valid_q;
	assign out_word  = {col_q, rh_q, rw_q, ry_q, rx_q};
	assign out_last  = last_q;

endmodule

[sv/seven_segment_number_overlay_core.sv]
// An accepted word passes the load, split, origin and place steps before its first rectangle.
// The digit splitter yields one digit per cycle and the segment emitter one rectangle per cycle
// while the output register is free; a word gives one rectangle per lit segment (up to 35).
// The next word is taken while the last rectangle still waits in the output register.
// Reset: screen_width 640, screen_height 480, controller idle, output register empty.
module seven_segment_number_overlay_core #(
	parameter int MAX_DIGITS = ssno_pkg::MAX_DIGITS
) (
	input  logic                               clk,
	input  logic                               arst_n,
	// value, justify, offset_h, offset_v, color, zero fill (low bit first)
	input  logic                               s_tvalid,
	output logic                               s_tready,
	input  logic [ssno_pkg::S_DATA_W-1:0]      s_tdata,
	// rect_x, rect_y, rect_w, rect_h, fill_color (low bit first)
	output logic                               m_tvalid,
	input  logic                               m_tready,
	output logic [ssno_pkg::M_DATA_W-1:0]      m_tdata,
	output logic                               m_tlast,
	// register writes
	input  logic                               cfg_valid,
	output logic                               cfg_ready,
	input  logic [ssno_pkg::CFG_IDX_W-1:0]     cfg_index,
	input  logic [ssno_pkg::SCREEN_W-1:0]      cfg_data
);

	logic [ssno_pkg::SCREEN_W-1:0] screen_width_q;
	logic [ssno_pkg::SCREEN_W-1:0] screen_height_q;
	ssno_pkg::cmd_t                cmd;
	ssno_pkg::sts_t                sts;

	// Configuration registers
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			screen_width_q  <= ssno_pkg::SCREEN_WIDTH_RST;
			screen_height_q <= ssno_pkg::SCREEN_HEIGHT_RST;
		end else if (cfg_valid && cfg_ready) begin
			if (cfg_index == ssno_pkg::REG_SCREEN_WIDTH) begin
				screen_width_q <= cfg_data;
			end else if (cfg_index == ssno_pkg::REG_SCREEN_HEIGHT) begin
				screen_height_q <= cfg_data;
			end
		end
	end

	ssno_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (s_tvalid),
		.ready  (s_tready),
		.sts    (sts),
		.cmd    (cmd)
	);

	ssno_dpath #(
		.MAX_DIGITS (MAX_DIGITS)
	) u_dpath (
		.clk           (clk),
		.arst_n        (arst_n),
		.cmd           (cmd),
		.sts           (sts),
		.in_word       (s_tdata),
		.screen_width  (screen_width_q),
		.screen_height (screen_height_q),
		.out_valid     (m_tvalid),
		.out_ready     (m_tready),
		.out_word      (m_tdata),
		.out_last      (m_tlast)
	);

	// A new word holds off further input until its rectangles are out
	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		(s_tvalid && s_tready) |=> !s_tready)
		else $error("input taken twice in a row");

	// A rectangle is only produced into a free output register
	a_emit_free: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.emit |-> (!m_tvalid || m_tready))
		else $error("rectangle overwrote a pending word");

	// The final rectangle of a number returns the block to idle
	a_final_idle: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.emit && sts.final_rect) |=> (s_tready && m_tvalid && m_tlast))
		else $error("final rectangle did not end the number");

	// Every bar is z by 3z or 3z by z
	a_bar_shape: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> ((9'(m_tdata[40:34]) == 9'(m_tdata[47:41]) * 9'd3) ||
			(9'(m_tdata[47:41]) == 9'(m_tdata[40:34]) * 9'd3)))
		else $error("segment bar has a wrong shape");

endmodule

[bench/ssno_checker.sv]
`timescale 1ns / 100ps

// Watches the input, output and register channels of the overlay core.
// Predicts the rectangle words for every accepted number and compares
// each accepted output word against the oldest prediction.
module ssno_checker
	import ssno_pkg::*;
(
	input  logic                 clk,
	input  logic                 arst_n,
	// value, justify, offset_h, offset_v, color, zero fill (low bit first)
	input  logic                 s_tvalid,
	input  logic                 s_tready,
	input  logic [S_DATA_W-1:0]  s_tdata,
	// rect_x, rect_y, rect_w, rect_h, fill_color (low bit first)
	input  logic                 m_tvalid,
	input  logic                 m_tready,
	input  logic [M_DATA_W-1:0]  m_tdata,
	input  logic                 m_tlast,
	input  logic                 cfg_valid,
	input  logic                 cfg_ready,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [SCREEN_W-1:0]  cfg_data,
	output int                   mismatch_count,
	output int                   rects_outstanding
);

	typedef struct packed {
		logic signed [COORD_W-1:0] x;
		logic signed [COORD_W-1:0] y;
		logic [SIZE_W-1:0]         w;
		logic [SIZE_W-1:0]         h;
		logic [COLOR_W-1:0]        fill;
		logic                      last;
	} rect_t;

	// Lit segments per digit, digit 9 in the top bits
	localparam logic [10*SEG_N-1:0] LIT_SEGS = {
		7'h6F, 7'h7F, 7'h25, 7'h7B, 7'h6B, 7'h2E, 7'h6D, 7'h5D, 7'h24, 7'h77
	};
	// Segment placement in zoom units, segment 6 in the top bits
	localparam logic [3*SEG_N-1:0] SEG_X = {3'd1, 3'd4, 3'd0, 3'd1, 3'd4, 3'd0, 3'd1};
	localparam logic [4*SEG_N-1:0] SEG_Y = {4'd8, 4'd5, 4'd5, 4'd4, 4'd1, 4'd1, 4'd0};
	localparam logic [SEG_N-1:0]   SEG_HORIZ = 7'b1001001;

	logic [SCREEN_W-1:0] screen_width;
	logic [SCREEN_W-1:0] screen_height;
	rect_t               pending_rects [$];
	rect_t               got;
	rect_t               want;

	// Expand one number into its rectangle words, in output order
	function automatic void predict_rects(input logic [S_DATA_W-1:0] word);
		int               val, offh, offv, z, zh, n, x, y, total, k, d, s;
		int               digit [MAX_DIGITS];
		logic [JUST_W-1:0] just;
		logic [SEG_N-1:0] lit;
		rect_t            r;
		val  = int'(word[VALUE_W-1:0]);
		just = word[VALUE_W +: JUST_W];
		offh = int'(word[VALUE_W+JUST_W +: OFFS_W]);
		offv = int'(word[VALUE_W+JUST_W+OFFS_W +: OFFS_W]);
		r.fill = word[VALUE_W+JUST_W+2*OFFS_W +: COLOR_W];

		// least significant digit first; excess high digits dropped
		n = 0;
		do begin
			digit[n] = val % 10;
			val = val / 10;
			n++;
		end while (val != 0 && n < MAX_DIGITS);

		z  = int'(screen_width) / 120 + 1;
		zh = int'(screen_height) / 80 + 1;
		if (zh < z)
			z = zh;

		if (just[0])
			x = int'(screen_width) - (offh + 7 * n - 2) * z;
		else
			x = offh * z;
		if (just[1])
			y = int'(screen_height) - (offv + 9) * z;
		else
			y = offv * z;

		total = 0;
		for (d = 0; d < n; d++)
			total += $countones(LIT_SEGS[digit[d]*SEG_N +: SEG_N]);

		// most significant digit first, segments in ascending order
		k = 0;
		for (d = n - 1; d >= 0; d--) begin
			lit = LIT_SEGS[digit[d]*SEG_N +: SEG_N];
			for (s = 0; s < SEG_N; s++) begin
				if (lit[s]) begin
					k++;
					r.x = COORD_W'(x + int'(SEG_X[s*3 +: 3]) * z);
					r.y = COORD_W'(y + int'(SEG_Y[s*4 +: 4]) * z);
					r.w = SIZE_W'(SEG_HORIZ[s] ? 3 * z : z);
					r.h = SIZE_W'(SEG_HORIZ[s] ? z : 3 * z);
					r.last = (k == total);
					pending_rects.push_back(r);
				end
			end
			x += 7 * z;
		end
	endfunction

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			screen_width = SCREEN_WIDTH_RST;
			screen_height = SCREEN_HEIGHT_RST;
			pending_rects.delete();
			mismatch_count = 0;
			rects_outstanding = 0;
		end else begin
			// register writes; other indexes are ignored
			if (cfg_valid && cfg_ready) begin
				if (cfg_index == REG_SCREEN_WIDTH)
					screen_width = cfg_data;
				else if (cfg_index == REG_SCREEN_HEIGHT)
					screen_height = cfg_data;
			end

			if (s_tvalid && s_tready)
				predict_rects(s_tdata);

			// compare output word against oldest prediction
			if (m_tvalid && m_tready) begin
				got.x = m_tdata[16:0];
				got.y = m_tdata[33:17];
				got.w = m_tdata[40:34];
				got.h = m_tdata[47:41];
				got.fill = m_tdata[79:48];
				got.last = m_tlast;
				if (pending_rects.size() == 0) begin
					$display("%0t unexpected rect: x=%0d y=%0d w=%0d h=%0d color=%h last=%b",
						$time, got.x, got.y, got.w, got.h, got.fill, got.last);
					mismatch_count++;
				end else begin
					want = pending_rects.pop_front();
					if (got !== want) begin
						$display("%0t rect mismatch: expected x=%0d y=%0d w=%0d h=%0d color=%h last=%b",
							$time, want.x, want.y, want.w, want.h, want.fill, want.last);
						$display("%0t                  actual x=%0d y=%0d w=%0d h=%0d color=%h last=%b",
							$time, got.x, got.y, got.w, got.h, got.fill, got.last);
						mismatch_count++;
					end
				end
			end

			rects_outstanding = pending_rects.size();
		end
	end

endmodule

[bench/tb_top.sv]
`timescale 1ns / 100ps

module tb_top;
	import ssno_pkg::*;

	localparam int LIMIT_CYCLES     = 1_000_000;
	localparam int HOLD_CYCLES      = 300;
	localparam int DRAIN_CYCLES     = 16;
	localparam int RANDOM_PER_PHASE = 94;

	// justify modes
	localparam logic [JUST_W-1:0] JUST_LEFT_TOP     = 2'b00;
	localparam logic [JUST_W-1:0] JUST_RIGHT_TOP    = 2'b01;
	localparam logic [JUST_W-1:0] JUST_LEFT_BOTTOM  = 2'b10;
	localparam logic [JUST_W-1:0] JUST_RIGHT_BOTTOM = 2'b11;

	// indexes past the register list
	localparam logic [CFG_IDX_W-1:0] REG_SPARE_2 = 2'd2;
	localparam logic [CFG_IDX_W-1:0] REG_SPARE_3 = 2'd3;

	logic                 clk;
	logic                 arst_n;
	logic                 s_tvalid;
	logic                 s_tready;
	logic [S_DATA_W-1:0]  s_tdata;
	logic                 m_tvalid;
	logic                 m_tready;
	logic [M_DATA_W-1:0]  m_tdata;
	logic                 m_tlast;
	logic                 cfg_valid;
	logic                 cfg_ready;
	logic [CFG_IDX_W-1:0] cfg_index;
	logic [SCREEN_W-1:0]  cfg_data;

	int   mismatch_count;
	int   rects_outstanding;
	int   tx_idle_pct;
	int   rx_idle_pct;
	logic hold_req;

	seven_segment_number_overlay_core uut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tlast  (m_tlast),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_index(cfg_index),
		.cfg_data (cfg_data)
	);

	ssno_checker chk (
		.clk              (clk),
		.arst_n           (arst_n),
		.s_tvalid         (s_tvalid),
		.s_tready         (s_tready),
		.s_tdata          (s_tdata),
		.m_tvalid         (m_tvalid),
		.m_tready         (m_tready),
		.m_tdata          (m_tdata),
		.m_tlast          (m_tlast),
		.cfg_valid        (cfg_valid),
		.cfg_ready        (cfg_ready),
		.cfg_index        (cfg_index),
		.cfg_data         (cfg_data),
		.mismatch_count   (mismatch_count),
		.rects_outstanding(rects_outstanding)
	);

	initial begin
		clk = 1'b0;
		forever #2 clk = ~clk;
	end

	// run limit
	initial begin
		repeat (LIMIT_CYCLES) @(posedge clk);
		$display("seven_segment_number_overlay_core verification failed");
		$finish;
	end

	// output side: random stalls, or a long hold when requested
	initial begin
		m_tready = 1'b0;
		forever begin
			@(negedge clk);
			if (hold_req) begin
				m_tready <= 1'b0;
				repeat (HOLD_CYCLES - 1) @(negedge clk);
				hold_req = 1'b0;
			end else begin
				m_tready <= ($urandom_range(0, 99) >= rx_idle_pct);
			end
		end
	end

	// Offer one number word; entered and left at a falling edge
	task automatic offer_number(input logic [VALUE_W-1:0] value, input logic [JUST_W-1:0] just,
			input logic [OFFS_W-1:0] offh, input logic [OFFS_W-1:0] offv,
			input logic [COLOR_W-1:0] color);
		while ($urandom_range(0, 99) < tx_idle_pct) begin
			s_tvalid <= 1'b0;
			@(negedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata <= {1'b0, color, offv, offh, just, value};
		@(posedge clk);
		while (!s_tready)
			@(posedge clk);
		@(negedge clk);
	endtask

	task automatic offer_random_number();
		logic [VALUE_W-1:0] value;
		logic [JUST_W-1:0]  just;
		logic [OFFS_W-1:0]  offh;
		logic [OFFS_W-1:0]  offv;
		case ($urandom_range(0, 9))
			0: value = VALUE_W'($urandom_range(0, 9));
			1: value = VALUE_W'($urandom_range(10, 99));
			2: value = VALUE_W'($urandom_range(100, 999));
			3: value = VALUE_W'($urandom_range(1000, 9999));
			4: value = VALUE_W'($urandom_range(100000, 131071));
			default: value = VALUE_W'($urandom_range(10000, 99999));
		endcase
		just = JUST_W'($urandom_range(0, 3));
		offh = OFFS_W'($urandom_range(0, 1023));
		offv = OFFS_W'($urandom_range(0, 1023));
		// edge offsets now and then
		if ($urandom_range(0, 7) == 0)
			offh = $urandom_range(0, 1) ? 10'd1023 : 10'd0;
		if ($urandom_range(0, 7) == 0)
			offv = $urandom_range(0, 1) ? 10'd1023 : 10'd0;
		offer_number(value, just, offh, offv, $urandom());
	endtask

	// Stop offering, wait for all rectangles, then let the block go idle
	task automatic settle_block();
		s_tvalid <= 1'b0;
		while (rects_outstanding != 0)
			@(negedge clk);
		repeat (DRAIN_CYCLES) @(negedge clk);
	endtask

	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [SCREEN_W-1:0] data);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= data;
		@(posedge clk);
		while (!cfg_ready)
			@(posedge clk);
		@(negedge clk);
		cfg_valid <= 1'b0;
		@(negedge clk);
	endtask

	initial begin
		int phase;
		arst_n = 1'b0;
		s_tvalid = 1'b0;
		s_tdata = '0;
		cfg_valid = 1'b0;
		cfg_index = REG_SCREEN_WIDTH;
		cfg_data = '0;
		tx_idle_pct = 0;
		rx_idle_pct = 0;
		hold_req = 1'b0;
		repeat (11) @(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// reset geometry 640x480: zero, overlong values, every digit, all modes
		offer_number(17'd0, JUST_LEFT_TOP, 10'd0, 10'd0, 32'h0000_0000);
		offer_number(17'd131071, JUST_RIGHT_BOTTOM, 10'd1023, 10'd1023, 32'hFFFF_FFFF);
		offer_number(17'd100000, JUST_RIGHT_TOP, 10'd5, 10'd7, 32'hA5A5_A5A5);
		offer_number(17'd12345, JUST_LEFT_BOTTOM, 10'd10, 10'd20, 32'h5A5A_5A5A);
		offer_number(17'd67890, JUST_LEFT_TOP, 10'd3, 10'd1, 32'h0123_4567);
		offer_number(17'd8, JUST_RIGHT_TOP, 10'd0, 10'd0, 32'h89AB_CDEF);
		offer_number(17'd99999, JUST_LEFT_TOP, 10'd1023, 10'd0, 32'h0000_FFFF);
		offer_number(17'd7, JUST_LEFT_BOTTOM, 10'd0, 10'd1023, 32'hFFFF_0000);
		offer_number(17'd1, JUST_RIGHT_BOTTOM, 10'd2, 10'd2, 32'h1234_5678);
		offer_number(17'd88888, JUST_RIGHT_BOTTOM, 10'd0, 10'd0, 32'hDEAD_BEEF);
		settle_block();

		// largest zoom
		write_reg(REG_SCREEN_WIDTH, 12'hFFF);
		write_reg(REG_SCREEN_HEIGHT, 12'hFFF);
		offer_number(17'd88888, JUST_LEFT_TOP, 10'd1023, 10'd1023, 32'hCAFE_F00D);
		offer_number(17'd88888, JUST_RIGHT_BOTTOM, 10'd1023, 10'd1023, 32'h0F0F_0F0F);
		offer_number(17'd0, JUST_RIGHT_BOTTOM, 10'd0, 10'd0, 32'hF0F0_F0F0);
		settle_block();

		// zero-sized surface
		write_reg(REG_SCREEN_WIDTH, 12'h000);
		write_reg(REG_SCREEN_HEIGHT, 12'h000);
		offer_number(17'd131071, JUST_RIGHT_BOTTOM, 10'd1023, 10'd1023, 32'h3333_CCCC);
		offer_number(17'd4, JUST_RIGHT_TOP, 10'd3, 10'd3, 32'hCCCC_3333);
		offer_number(17'd99999, JUST_LEFT_TOP, 10'd0, 10'd0, 32'h7777_8888);
		settle_block();

		// writes past the register list are dropped; then a height-limited zoom
		write_reg(REG_SPARE_2, 12'hFFF);
		write_reg(REG_SPARE_3, 12'h555);
		write_reg(REG_SCREEN_WIDTH, 12'hFFF);
		write_reg(REG_SCREEN_HEIGHT, 12'd240);
		offer_number(17'd23456, JUST_RIGHT_TOP, 10'd17, 10'd9, 32'h2468_ACE0);
		offer_number(17'd5, JUST_LEFT_BOTTOM, 10'd40, 10'd30, 32'h1357_9BDF);
		settle_block();

		// random numbers under three idle patterns, fresh geometry each time
		for (phase = 0; phase < 3; phase++) begin
			write_reg(REG_SCREEN_WIDTH, SCREEN_W'($urandom_range(0, 4095)));
			write_reg(REG_SCREEN_HEIGHT, SCREEN_W'($urandom_range(0, 4095)));
			tx_idle_pct = (phase == 0) ? 15 : (phase == 1) ? 74 : 0;
			rx_idle_pct = (phase == 0) ? 74 : (phase == 1) ? 15 : 0;
			// long output stall while input keeps coming
			if (phase == 2)
				hold_req = 1'b1;
			repeat (RANDOM_PER_PHASE) offer_random_number();
			settle_block();
		end

		if (mismatch_count == 0)
			$display("seven_segment_number_overlay_core verification clean");
		else
			$display("seven_segment_number_overlay_core verification failed");
		$finish;
	end

endmodule

[sim.f]
sv/ssno_pkg.sv
sv/ssno_ctrl.sv
sv/ssno_dpath.sv
sv/seven_segment_number_overlay_core.sv
bench/ssno_checker.sv
bench/tb_top.sv
